// ----- rtl/core/cr_pkg.sv -----
// Shared types, constants and arithmetic helpers for the spline evaluator.
`timescale 1ns / 1ps
package cr_pkg;

	localparam int MAX_POINTS = 64;
	localparam int PIDX_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = PIDX_W + 1;
	localparam int COORD_W    = 32;
	localparam int FRAC_W     = 16;
	localparam int T_W        = 24;
	localparam int ACC_W      = 40;
	localparam int PROD_W     = ACC_W + FRAC_W + 1;
	localparam int PIPE_LEN   = 10;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	typedef struct packed {
		logic [PIDX_W-1:0] i0;
		logic [PIDX_W-1:0] i1;
		logic [PIDX_W-1:0] i2;
		logic [PIDX_W-1:0] i3;
	} rd_addr_t;

	function automatic logic signed [ACC_W-1:0] sx(input logic signed [COORD_W-1:0] p);
		return {{(ACC_W-COORD_W){p[COORD_W-1]}}, p};
	endfunction

	function automatic logic signed [PROD_W-1:0] mulf(input logic signed [ACC_W-1:0] a,
			input logic [FRAC_W-1:0] f);
		logic signed [PROD_W-1:0] ae;
		logic signed [PROD_W-1:0] fe;
		ae = {{(PROD_W-ACC_W){a[ACC_W-1]}}, a};
		fe = {{(PROD_W-FRAC_W){1'b0}}, f};
		return ae * fe;
	endfunction

	// round to nearest, halves up, drop FRAC_W bits
	function automatic logic signed [ACC_W-1:0] rnd(input logic signed [PROD_W-1:0] m);
		logic signed [PROD_W-1:0] t;
		t = m + (PROD_W'(1) <<< (FRAC_W-1));
		return t[FRAC_W+ACC_W-1:FRAC_W];
	endfunction

	function automatic logic signed [COORD_W-1:0] half_sat(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W-1:0] t;
		logic signed [ACC_W-2:0] h;
		t = a + ACC_W'(1);
		h = t[ACC_W-1:1];
		if (h > (ACC_W-1)'(64'sd2147483647))
			return 32'sh7FFFFFFF;
		else if (h < (ACC_W-1)'(-64'sd2147483648))
			return 32'sh80000000;
		else
			return h[COORD_W-1:0];
	endfunction

endpackage

// ----- rtl/core/cr_index.sv -----
// Segment and fraction from global parameter, neighbor address generation.
`timescale 1ns / 1ps
module cr_index (
	input  logic                        clk,
	input  logic                        en,
	input  logic [cr_pkg::T_W-1:0]      global_t,
	input  logic [cr_pkg::CNT_W-1:0]    cnt,
	output logic [cr_pkg::FRAC_W-1:0]   f_s1,
	output cr_pkg::rd_addr_t            raddr
);
	import cr_pkg::*;

	localparam int PRODI_W = FRAC_W + CNT_W;

	logic [CNT_W-1:0]   n;
	logic [PIDX_W-1:0]  nm1;
	logic [PRODI_W-1:0] prod;
	logic [PIDX_W-1:0]  seg_s1;
	logic [PIDX_W-1:0]  i2;

	always_comb begin
		if (cnt == '0)
			n = CNT_W'(1);
		else if (cnt > CNT_W'(MAX_POINTS))
			n = CNT_W'(MAX_POINTS);
		else
			n = cnt;
		nm1 = PIDX_W'(n - CNT_W'(1));
	end

	// integer part of t contributes whole loops, only the fraction matters
	assign prod = {{CNT_W{1'b0}}, global_t[FRAC_W-1:0]} * {{FRAC_W{1'b0}}, n};

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1 <= prod[FRAC_W+PIDX_W-1:FRAC_W];
			f_s1   <= prod[FRAC_W-1:0];
		end
	end

	always_comb begin
		i2       = (seg_s1 == nm1) ? '0 : PIDX_W'(seg_s1 + PIDX_W'(1));
		raddr.i0 = (seg_s1 == '0) ? nm1 : PIDX_W'(seg_s1 - PIDX_W'(1));
		raddr.i1 = seg_s1;
		raddr.i2 = i2;
		raddr.i3 = (i2 == nm1) ? '0 : PIDX_W'(i2 + PIDX_W'(1));
	end

endmodule

// ----- rtl/core/cr_point_mem.sv -----
// Control point table: two mirrored memories, two read ports each.
`timescale 1ns / 1ps
module cr_point_mem (
	input  logic                       clk,
	input  logic                       en,
	input  logic                       we,
	input  logic [cr_pkg::PIDX_W-1:0]  waddr,
	input  cr_pkg::point_t             wdata,
	input  cr_pkg::rd_addr_t           raddr,
	output cr_pkg::point_t             p0_s2,
	output cr_pkg::point_t             p1_s2,
	output cr_pkg::point_t             p2_s2,
	output cr_pkg::point_t             p3_s2
);
	import cr_pkg::*;

	point_t mem_a [MAX_POINTS];
	point_t mem_b [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_a[waddr] <= wdata;
			mem_b[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s2 <= mem_a[raddr.i0];
			p1_s2 <= mem_a[raddr.i1];
			p2_s2 <= mem_b[raddr.i2];
			p3_s2 <= mem_b[raddr.i3];
		end
	end

endmodule

// ----- rtl/core/cr_lane.sv -----
// One coordinate: basis coefficients and Horner evaluation of position and tangent.
`timescale 1ns / 1ps
module cr_lane (
	input  logic                              clk,
	input  logic                              en,
	input  logic [cr_pkg::FRAC_W-1:0]         f_s2,
	input  logic signed [cr_pkg::COORD_W-1:0] p0,
	input  logic signed [cr_pkg::COORD_W-1:0] p1,
	input  logic signed [cr_pkg::COORD_W-1:0] p2,
	input  logic signed [cr_pkg::COORD_W-1:0] p3,
	output logic signed [cr_pkg::COORD_W-1:0] pos,
	output logic signed [cr_pkg::COORD_W-1:0] deriv
);
	import cr_pkg::*;

	logic signed [ACC_W-1:0]  e0, e1, e2, e3, d, c3, c2;
	logic signed [ACC_W-1:0]  a3_s3, a2_s3, a1_s3, a0_s3, d3_s3, d2_s3;
	logic [FRAC_W-1:0]        f_s3, f_s4, f_s5, f_s6, f_s7;
	logic signed [PROD_W-1:0] m_s4, n_s4;
	logic signed [ACC_W-1:0]  a2_s4, a1_s4, a0_s4, d2_s4;
	logic signed [ACC_W-1:0]  acc_s5, dac_s5, a1_s5, a0_s5;
	logic signed [PROD_W-1:0] m_s6, n_s6;
	logic signed [ACC_W-1:0]  a1_s6, a0_s6;
	logic signed [ACC_W-1:0]  acc_s7, dac_s7, a0_s7;
	logic signed [PROD_W-1:0] m_s8;
	logic signed [ACC_W-1:0]  a0_s8;
	logic signed [COORD_W-1:0] der_s8, der_s9;
	logic signed [ACC_W-1:0]  acc_s9;
	logic signed [COORD_W-1:0] pos_s10, der_s10;

	always_comb begin
		e0 = sx(p0);
		e1 = sx(p1);
		e2 = sx(p2);
		e3 = sx(p3);
		d  = e1 - e2;
		c3 = e3 - e0 + d + (d <<< 1);
		c2 = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a3_s3 <= c3;
			a2_s3 <= c2;
			a1_s3 <= e2 - e0;
			a0_s3 <= e1 <<< 1;
			d3_s3 <= c3 + (c3 <<< 1);
			d2_s3 <= c2 <<< 1;
			f_s3  <= f_s2;

			m_s4  <= mulf(a3_s3, f_s3);
			n_s4  <= mulf(d3_s3, f_s3);
			a2_s4 <= a2_s3;
			d2_s4 <= d2_s3;
			a1_s4 <= a1_s3;
			a0_s4 <= a0_s3;
			f_s4  <= f_s3;

			acc_s5 <= rnd(m_s4) + a2_s4;
			dac_s5 <= rnd(n_s4) + d2_s4;
			a1_s5  <= a1_s4;
			a0_s5  <= a0_s4;
			f_s5   <= f_s4;

			m_s6  <= mulf(acc_s5, f_s5);
			n_s6  <= mulf(dac_s5, f_s5);
			a1_s6 <= a1_s5;
			a0_s6 <= a0_s5;
			f_s6  <= f_s5;

			acc_s7 <= rnd(m_s6) + a1_s6;
			dac_s7 <= rnd(n_s6) + a1_s6;
			a0_s7  <= a0_s6;
			f_s7   <= f_s6;

			m_s8   <= mulf(acc_s7, f_s7);
			der_s8 <= half_sat(dac_s7);
			a0_s8  <= a0_s7;

			acc_s9 <= rnd(m_s8) + a0_s8;
			der_s9 <= der_s8;

			pos_s10 <= half_sat(acc_s9);
			der_s10 <= der_s9;
		end
	end

	assign pos   = pos_s10;
	assign deriv = der_s10;

endmodule

// ----- rtl/core/catmull_rom_loop_evaluator.sv -----
// Top level: closed-loop Catmull-Rom spline evaluator over a control point table.
//
//  channel | direction | handshake           | word
//  cfg     | in        | cfg_we              | cfg_data (loop length)
//  in      | in        | in_valid / in_stall | func, point_index, point_x/y/z, global_t
//  out     | out       | out_valid/out_stall | pos_x/y/z, deriv_x/y/z
//
// One word accepted per cycle while in_stall is low. Ten register stages lie between
// an evaluate word's inputs and the outputs: index, table read, coefficients,
// three multiply/round pairs, final halving and saturation.
// Load words write the table at acceptance and return nothing.
// A stalled result freezes the whole pipe and raises in_stall in the same cycle.
// Reset clears control state and sets the loop length to 4; the table is not cleared.
`timescale 1ns / 1ps
module catmull_rom_loop_evaluator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cr_pkg::CNT_W-1:0]          cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              func,
	input  logic [cr_pkg::PIDX_W-1:0]         point_index,
	input  logic signed [cr_pkg::COORD_W-1:0] point_x,
	input  logic signed [cr_pkg::COORD_W-1:0] point_y,
	input  logic signed [cr_pkg::COORD_W-1:0] point_z,
	input  logic [cr_pkg::T_W-1:0]            global_t,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [cr_pkg::COORD_W-1:0] pos_x,
	output logic signed [cr_pkg::COORD_W-1:0] pos_y,
	output logic signed [cr_pkg::COORD_W-1:0] pos_z,
	output logic signed [cr_pkg::COORD_W-1:0] deriv_x,
	output logic signed [cr_pkg::COORD_W-1:0] deriv_y,
	output logic signed [cr_pkg::COORD_W-1:0] deriv_z
);
	import cr_pkg::*;

	logic [CNT_W-1:0]    n_pts_q;
	logic [PIPE_LEN-1:0] vld_q;
	logic                en;
	logic                acc_in;
	logic [FRAC_W-1:0]   f_s1, f_s2;
	rd_addr_t            raddr;
	point_t              wdata;
	point_t              p0_s2, p1_s2, p2_s2, p3_s2;

	assign en       = !(vld_q[PIPE_LEN-1] && out_stall);
	assign in_stall = !en;
	assign acc_in   = in_valid && en;
	assign out_valid = vld_q[PIPE_LEN-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_pts_q <= CNT_W'(4);
		end else if (cfg_we) begin
			n_pts_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LEN-2:0], acc_in && (func == FUNC_EVAL)};
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			f_s2 <= f_s1;
	end

	assign wdata = '{x: point_x, y: point_y, z: point_z};

	cr_index u_index (
		.clk      (clk),
		.en       (en),
		.global_t (global_t),
		.cnt      (n_pts_q),
		.f_s1     (f_s1),
		.raddr    (raddr)
	);

	cr_point_mem u_mem (
		.clk   (clk),
		.en    (en),
		.we    (acc_in && (func == FUNC_LOAD)),
		.waddr (point_index),
		.wdata (wdata),
		.raddr (raddr),
		.p0_s2 (p0_s2),
		.p1_s2 (p1_s2),
		.p2_s2 (p2_s2),
		.p3_s2 (p3_s2)
	);

	cr_lane u_lane_x (
		.clk (clk), .en (en), .f_s2 (f_s2),
		.p0 (p0_s2.x), .p1 (p1_s2.x), .p2 (p2_s2.x), .p3 (p3_s2.x),
		.pos (pos_x), .deriv (deriv_x)
	);

	cr_lane u_lane_y (
		.clk (clk), .en (en), .f_s2 (f_s2),
		.p0 (p0_s2.y), .p1 (p1_s2.y), .p2 (p2_s2.y), .p3 (p3_s2.y),
		.pos (pos_y), .deriv (deriv_y)
	);

	cr_lane u_lane_z (
		.clk (clk), .en (en), .f_s2 (f_s2),
		.p0 (p0_s2.z), .p1 (p1_s2.z), .p2 (p2_s2.z), .p3 (p3_s2.z),
		.pos (pos_z), .deriv (deriv_z)
	);

endmodule
